### rtl/ilp_pkg.sv
// Shared constants for the integer literal parser.
// Character codes, result status codes and default widths; no dependencies.
`timescale 1ns / 1ps

package ilp_pkg;

  localparam int unsigned DefaultValueBits = 64;
  localparam int unsigned OutValueBits     = 64;
  localparam int unsigned StatusBits       = 2;
  localparam int unsigned OutDataBits      = 72;

  localparam logic [StatusBits-1:0] StatusOk       = 2'd0;
  localparam logic [StatusBits-1:0] StatusNoDigits = 2'd1;
  localparam logic [StatusBits-1:0] StatusOverflow = 2'd2;

  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharUnder = 8'h5F;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowZ  = 8'h7A;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpZ   = 8'h5A;
  localparam logic [7:0] CharLowX  = 8'h78;
  localparam logic [7:0] CharUpX   = 8'h58;
  localparam logic [7:0] CharLowB  = 8'h62;
  localparam logic [7:0] CharUpB   = 8'h42;
  localparam logic [7:0] CharLowO  = 8'h6F;
  localparam logic [7:0] CharUpO   = 8'h4F;

endpackage

### rtl/integer_literal_parser.sv
// Integer literal parser, top level: input register, ilp_core, result register.
// Depends on ilp_pkg and ilp_core.
// A last character passes the input register and then the result register behind m_axis_tvalid.
// Throughput: one character per cycle; a last character waits while a result is stalled.
// Reset (rst_ni low, asynchronous) empties both registers and returns the parser to its start.
`timescale 1ns / 1ps

module integer_literal_parser #(
  parameter int unsigned VALUE_BITS = ilp_pkg::DefaultValueBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // [7:0] char_code
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [ilp_pkg::OutDataBits-1:0]   m_axis_tdata    // [63:0] value, [65:64] status
);

  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_last_q;
  logic       out_valid_q;
  logic [ilp_pkg::OutDataBits-1:0] out_data_q;
  logic       out_free, advance;

  logic [ilp_pkg::OutValueBits-1:0] res_value;
  logic [ilp_pkg::StatusBits-1:0]   res_status;

  assign out_free      = !out_valid_q || m_axis_tready;
  // A character that gives no result never waits for the output side.
  assign advance       = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  ilp_core #(
    .VALUE_BITS(VALUE_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .char_i  (in_char_q),
    .last_i  (in_last_q),
    .value_o (res_value),
    .status_o(res_status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_data_q <= ilp_pkg::OutDataBits'({res_status, res_value});
    end
  end

endmodule

### rtl/ilp_core.sv
// Parser state and per-character update for the integer literal parser.
// Uses ilp_pkg for character and status codes.
`timescale 1ns / 1ps

module ilp_core #(
  parameter int unsigned VALUE_BITS = ilp_pkg::DefaultValueBits
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  logic [7:0]                              char_i,
  input  logic                                    last_i,
  output logic [ilp_pkg::OutValueBits-1:0]        value_o,
  output logic [ilp_pkg::StatusBits-1:0]          status_o
);

  localparam int unsigned MagBits  = VALUE_BITS - 1;
  localparam int unsigned ProdBits = MagBits + 5;

  typedef enum logic [2:0] {
    PhStart,
    PhMinus,
    PhPrefix,
    PhZero,
    PhDigits,
    PhDone
  } phase_e;

  typedef enum logic [1:0] {
    RadixDec,
    RadixHex,
    RadixBin,
    RadixOct
  } radix_e;

  phase_e               phase_q, phase_d;
  radix_e               radix_q, radix_d;
  logic                 neg_q, neg_d;
  logic                 seen_q, seen_d;
  logic                 ovf_q, ovf_d;
  logic [MagBits-1:0]   mag_q, mag_d;

  // Value of a character as a digit; 63 marks a character that is no digit.
  function automatic logic [5:0] digit_val(input logic [7:0] c);
    logic [5:0] r;
    r = 6'd63;
    if (c >= ilp_pkg::CharZero && c <= ilp_pkg::CharNine) begin
      r = 6'(c - ilp_pkg::CharZero);
    end else if (c >= ilp_pkg::CharLowA && c <= ilp_pkg::CharLowZ) begin
      r = 6'(c - ilp_pkg::CharLowA) + 6'd10;
    end else if (c >= ilp_pkg::CharUpA && c <= ilp_pkg::CharUpZ) begin
      r = 6'(c - ilp_pkg::CharUpA) + 6'd10;
    end
    return r;
  endfunction

  logic               is_dec_digit;
  radix_e             step_radix;
  logic [5:0]         dig;
  logic [5:0]         base;
  logic [ProdBits-1:0] prod;
  logic               step_under, step_bad, step_ovf;

  assign is_dec_digit = (char_i >= ilp_pkg::CharZero) && (char_i <= ilp_pkg::CharNine);
  assign dig          = digit_val(char_i);

  // Radix that a digit character is judged against in this cycle.
  always_comb begin
    priority if (phase_q == PhDigits) begin
      step_radix = radix_q;
    end else if (phase_q == PhZero && is_dec_digit) begin
      step_radix = RadixOct;
    end else begin
      step_radix = RadixDec;
    end
  end

  always_comb begin
    unique case (step_radix)
      RadixDec: begin
        base = 6'd10;
        prod = (ProdBits'(mag_q) << 3) + (ProdBits'(mag_q) << 1);
      end
      RadixHex: begin
        base = 6'd16;
        prod = ProdBits'(mag_q) << 4;
      end
      RadixBin: begin
        base = 6'd2;
        prod = ProdBits'(mag_q) << 1;
      end
      default: begin
        base = 6'd8;
        prod = ProdBits'(mag_q) << 3;
      end
    endcase
    prod = prod + ProdBits'(dig);
  end

  assign step_under = (char_i == ilp_pkg::CharUnder);
  assign step_bad   = !step_under && (dig >= base);
  // The limit is all ones in MagBits, so any bit above it means overflow.
  assign step_ovf   = |prod[ProdBits-1:MagBits];

  always_comb begin
    logic take;
    take    = 1'b0;
    phase_d = phase_q;
    radix_d = radix_q;
    neg_d   = neg_q;
    seen_d  = seen_q;
    ovf_d   = ovf_q;
    mag_d   = mag_q;

    unique case (phase_q)
      PhStart, PhMinus, PhPrefix: begin
        if (phase_q == PhStart && char_i == ilp_pkg::CharMinus) begin
          neg_d   = 1'b1;
          phase_d = PhMinus;
        end else if (phase_q != PhPrefix && char_i == ilp_pkg::CharPlus) begin
          neg_d   = 1'b0;
          phase_d = PhPrefix;
        end else if (char_i == ilp_pkg::CharZero) begin
          phase_d = PhZero;
          seen_d  = 1'b1;
          mag_d   = '0;
        end else begin
          radix_d = RadixDec;
          phase_d = PhDigits;
          take    = 1'b1;
        end
      end
      PhZero: begin
        phase_d = PhDigits;
        if (char_i == ilp_pkg::CharLowX || char_i == ilp_pkg::CharUpX) begin
          radix_d = RadixHex;
          seen_d  = 1'b0;
        end else if (char_i == ilp_pkg::CharLowB || char_i == ilp_pkg::CharUpB) begin
          radix_d = RadixBin;
          seen_d  = 1'b0;
        end else if (char_i == ilp_pkg::CharLowO || char_i == ilp_pkg::CharUpO) begin
          radix_d = RadixOct;
          seen_d  = 1'b0;
        end else begin
          radix_d = step_radix;
          take    = 1'b1;
        end
      end
      PhDigits: begin
        take = 1'b1;
      end
      default: begin
        phase_d = PhDone;
      end
    endcase

    if (take && !step_under) begin
      if (step_bad) begin
        phase_d = PhDone;
      end else begin
        seen_d = 1'b1;
        if (!ovf_q) begin
          if (step_ovf) begin
            ovf_d = 1'b1;
          end else begin
            mag_d = prod[MagBits-1:0];
          end
        end
      end
    end
  end

  logic signed [VALUE_BITS-1:0] val_s;

  assign val_s = neg_d ? -$signed({1'b0, mag_d}) : $signed({1'b0, mag_d});

  always_comb begin
    priority if (!seen_d) begin
      status_o = ilp_pkg::StatusNoDigits;
      value_o  = '0;
    end else if (ovf_d) begin
      status_o = ilp_pkg::StatusOverflow;
      value_o  = '0;
    end else begin
      status_o = ilp_pkg::StatusOk;
      value_o  = ilp_pkg::OutValueBits'(val_s);
    end
  end

  // The last character of a literal returns the parser to its start state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart;
      radix_q <= RadixDec;
      neg_q   <= 1'b0;
      seen_q  <= 1'b0;
      ovf_q   <= 1'b0;
      mag_q   <= '0;
    end else if (en_i) begin
      if (last_i) begin
        phase_q <= PhStart;
        radix_q <= RadixDec;
        neg_q   <= 1'b0;
        seen_q  <= 1'b0;
        ovf_q   <= 1'b0;
        mag_q   <= '0;
      end else begin
        phase_q <= phase_d;
        radix_q <= radix_d;
        neg_q   <= neg_d;
        seen_q  <= seen_d;
        ovf_q   <= ovf_d;
        mag_q   <= mag_d;
      end
    end
  end

endmodule

### rtl/ilp_checker.sv
// Port-level checks for integer_literal_parser, attached by a bind statement.
// Depends on ilp_pkg.
`timescale 1ns / 1ps

module ilp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            s_axis_tlast,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [ilp_pkg::OutDataBits-1:0] m_axis_tdata
);

  // A result holds while the sink stalls it.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[65:64] != 2'd3)
    else $error("undefined status code");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[65:64] != ilp_pkg::StatusOk |-> m_axis_tdata[63:0] == 64'd0)
    else $error("nonzero value with error status");

  // The most negative 64-bit value can never be produced.
  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[63] && m_axis_tdata[62:0] == 63'd0))
    else $error("value out of range");

  // A new result follows an accepted last-character transaction.
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
    else $error("result without a last character");

endmodule

bind integer_literal_parser ilp_checker u_ilp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

### test/integer_literal_parser_tb.sv
// Self-checking testbench for integer_literal_parser: streams literal text in,
// predicts each value and status, and checks every result. Depends on ilp_pkg and the RTL.
`timescale 1ns / 1ps

module integer_literal_parser_tb;

  localparam int unsigned StallLimit   = 1000;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned ItemsPerPass = 375;
  localparam logic [63:0] MagLimit     = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    PhStart, PhMinus, PhPrefix, PhZero, PhDigits, PhDone
  } parse_phase_e;

  typedef enum logic [1:0] {RadixDec, RadixHex, RadixBin, RadixOct} radix_e;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
  } literal_result_t;

  // Tracks the parser state alongside the block and holds the results still due.
  class literal_tracker;
    parse_phase_e    phase;
    bit              negative;
    radix_e          radix;
    longint unsigned magnitude;
    bit              digit_seen;
    bit              overflowed;
    literal_result_t pending[$];
    int              errors;

    function void clear_state();
      phase      = PhStart;
      negative   = 1'b0;
      radix      = RadixDec;
      magnitude  = '0;
      digit_seen = 1'b0;
      overflowed = 1'b0;
    endfunction

    function longint unsigned digit_value(logic [7:0] c);
      if (c >= ilp_pkg::CharZero && c <= ilp_pkg::CharNine) begin
        return 64'(c - ilp_pkg::CharZero);
      end
      if (c >= ilp_pkg::CharLowA && c <= ilp_pkg::CharLowZ) begin
        return 64'(c - ilp_pkg::CharLowA) + 64'd10;
      end
      if (c >= ilp_pkg::CharUpA && c <= ilp_pkg::CharUpZ) begin
        return 64'(c - ilp_pkg::CharUpA) + 64'd10;
      end
      return 64'd99;
    endfunction

    function longint unsigned base_of(radix_e r);
      case (r)
        RadixHex: return 64'd16;
        RadixBin: return 64'd2;
        RadixOct: return 64'd8;
        default:  return 64'd10;
      endcase
    endfunction

    function void take_digit(logic [7:0] c);
      longint unsigned b;
      longint unsigned d;
      if (c == ilp_pkg::CharUnder) return;
      b = base_of(radix);
      d = digit_value(c);
      if (d >= b) begin
        phase = PhDone;
        return;
      end
      digit_seen = 1'b1;
      if (overflowed) return;
      // Growth stops for good once the next step would pass the largest magnitude.
      if (magnitude > (MagLimit - d) / b) begin
        overflowed = 1'b1;
        return;
      end
      magnitude = magnitude * b + d;
    endfunction

    function void after_sign(logic [7:0] c);
      if (c == ilp_pkg::CharZero) begin
        phase      = PhZero;
        digit_seen = 1'b1;
        magnitude  = '0;
      end else begin
        radix = RadixDec;
        phase = PhDigits;
        take_digit(c);
      end
    endfunction

    function void note_char(logic [7:0] c, logic fin);
      literal_result_t res;
      case (phase)
        PhStart: begin
          if (c == ilp_pkg::CharMinus) begin
            negative = 1'b1;
            phase    = PhMinus;
          end else if (c == ilp_pkg::CharPlus) begin
            negative = 1'b0;
            phase    = PhPrefix;
          end else begin
            after_sign(c);
          end
        end
        PhMinus: begin
          if (c == ilp_pkg::CharPlus) begin
            negative = 1'b0;
            phase    = PhPrefix;
          end else begin
            after_sign(c);
          end
        end
        PhPrefix: after_sign(c);
        PhZero: begin
          phase = PhDigits;
          if (c == ilp_pkg::CharLowX || c == ilp_pkg::CharUpX) begin
            radix      = RadixHex;
            digit_seen = 1'b0;
          end else if (c == ilp_pkg::CharLowB || c == ilp_pkg::CharUpB) begin
            radix      = RadixBin;
            digit_seen = 1'b0;
          end else if (c == ilp_pkg::CharLowO || c == ilp_pkg::CharUpO) begin
            radix      = RadixOct;
            digit_seen = 1'b0;
          end else if (c >= ilp_pkg::CharZero && c <= ilp_pkg::CharNine) begin
            radix = RadixOct;
            take_digit(c);
          end else begin
            radix = RadixDec;
            take_digit(c);
          end
        end
        PhDigits: take_digit(c);
        default: phase = PhDone;
      endcase
      if (!fin) return;
      res.value = 64'd0;
      if (!digit_seen) begin
        res.status = ilp_pkg::StatusNoDigits;
      end else if (overflowed) begin
        res.status = ilp_pkg::StatusOverflow;
      end else begin
        res.status = ilp_pkg::StatusOk;
        res.value  = negative ? 64'd0 - magnitude : magnitude;
      end
      pending.push_back(res);
      clear_state();
    endfunction

    function void check_result(logic [ilp_pkg::OutDataBits-1:0] data);
      literal_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual value %0d status %0d",
                 $time, $signed(data[63:0]), data[65:64]);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (data[65:64] !== want.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, want.status, data[65:64]);
        errors++;
      end
      if (data[63:0] !== want.value) begin
        $display("%0t: value mismatch, expected %0d, actual %0d",
                 $time, $signed(want.value), $signed(data[63:0]));
        errors++;
      end
    endfunction
  endclass

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [7:0]                      s_axis_tdata  = 8'd0;
  logic                            s_axis_tlast  = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [ilp_pkg::OutDataBits-1:0] m_axis_tdata;

  literal_tracker tracker;
  logic [7:0]     lit_chars[$];
  int unsigned    items_sent   = 0;
  int unsigned    send_idle    = 0;
  int unsigned    recv_stall   = 0;
  int unsigned    quiet_cycles = 0;

  integer_literal_parser DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);
  end

  // Transaction monitor and watchdog on the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        tracker.check_result(m_axis_tdata);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        tracker.note_char(s_axis_tdata, s_axis_tlast);
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, StallLimit);
        $display("** integer_literal_parser: FAILED **");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_char(logic [7:0] c, logic fin);
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_literal();
    for (int i = 0; i < lit_chars.size(); i++) begin
      send_char(lit_chars[i], i == lit_chars.size() - 1);
    end
  endtask

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      lit_chars.push_back(s[i]);
    end
  endfunction

  task automatic send_text(string s);
    lit_chars.delete();
    push_text(s);
    send_literal();
  endtask

  function automatic string boundary_text(int unsigned pick);
    case (pick)
      0: return "9223372036854775807";
      1: return "9223372036854775808";
      2: return "-9223372036854775807";
      3: return "-9223372036854775808";
      4: return "0x7FFFFFFFFFFFFFFF";
      5: return "0x8000000000000000";
      6: return "0o777777777777777777777";
      default: return "-0o1000000000000000000000";
    endcase
  endfunction

  function automatic logic [7:0] random_digit(radix_e r);
    int unsigned v;
    case (r)
      RadixHex: v = $urandom_range(0, 15);
      RadixBin: v = $urandom_range(0, 1);
      RadixOct: v = $urandom_range(0, 7);
      default:  v = $urandom_range(0, 9);
    endcase
    if (v < 10) return 8'(ilp_pkg::CharZero + v);
    return 8'(($urandom_range(0, 1) ? ilp_pkg::CharUpA : ilp_pkg::CharLowA) + v - 10);
  endfunction

  // Mostly well-formed literals with random content; some noise and boundary values.
  function automatic void make_literal();
    int unsigned pick;
    int unsigned ndig;
    radix_e      r;
    bit          up;
    lit_chars.delete();
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 6)) lit_chars.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (pick < 14) begin
      push_text(boundary_text($urandom_range(0, 7)));
      return;
    end
    pick = $urandom_range(0, 19);
    if (pick < 6) begin
      lit_chars.push_back(ilp_pkg::CharMinus);
    end else if (pick < 8) begin
      lit_chars.push_back(ilp_pkg::CharPlus);
    end else if (pick == 8) begin
      lit_chars.push_back(ilp_pkg::CharMinus);
      lit_chars.push_back(ilp_pkg::CharPlus);
    end
    up = 1'($urandom_range(0, 1));
    r  = RadixDec;
    case ($urandom_range(0, 4))
      1: begin
        r = RadixHex;
        lit_chars.push_back(ilp_pkg::CharZero);
        lit_chars.push_back(up ? ilp_pkg::CharUpX : ilp_pkg::CharLowX);
      end
      2: begin
        r = RadixBin;
        lit_chars.push_back(ilp_pkg::CharZero);
        lit_chars.push_back(up ? ilp_pkg::CharUpB : ilp_pkg::CharLowB);
      end
      3: begin
        r = RadixOct;
        lit_chars.push_back(ilp_pkg::CharZero);
        lit_chars.push_back(up ? ilp_pkg::CharUpO : ilp_pkg::CharLowO);
      end
      4: begin
        r = RadixOct;
        lit_chars.push_back(ilp_pkg::CharZero);
      end
      default: r = RadixDec;
    endcase
    if ($urandom_range(0, 19) == 0) lit_chars.push_back(ilp_pkg::CharUnder);
    pick = $urandom_range(0, 19);
    if (pick == 0) ndig = 0;
    else if (pick < 4) ndig = $urandom_range(15, 24);
    else ndig = $urandom_range(1, 6);
    repeat (ndig) begin
      if ($urandom_range(0, 9) == 0) lit_chars.push_back(ilp_pkg::CharUnder);
      lit_chars.push_back(random_digit(r));
    end
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) lit_chars.push_back(8'($urandom_range(0, 255)));
    end
    if (lit_chars.size() == 0) lit_chars.push_back(8'($urandom_range(0, 255)));
  endfunction

  initial begin
    tracker = new();
    tracker.clear_state();
    tracker.errors = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: lone zero, sign handling, each prefix, old-style octal, underscores,
    // no digits, and a non-digit that ends the number.
    send_text("0");
    send_text("-+9");
    send_text("0X");
    send_text("0b1");
    send_text("0o7");
    send_text("017");
    send_text("09");
    send_text("_5");
    send_text("0_7");
    send_text("-");
    send_text("1 2");
    send_char(8'hFF, 1'b1);

    for (int pass = 0; pass < 4; pass++) begin
      case (pass)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 50; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 50; end
        default: begin send_idle = 28; recv_stall = 28; end
      endcase
      while (items_sent < (pass + 1) * ItemsPerPass) begin
        make_literal();
        send_literal();
      end
    end
    s_axis_tvalid <= 1'b0;

    while (tracker.pending.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("** integer_literal_parser: PASSED **");
    end else begin
      $display("** integer_literal_parser: FAILED **");
    end
    $finish;
  end

endmodule
